/* sv/bpt_pkg.sv */
package bpt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int W_BITS = 24;

  typedef struct packed {
    logic signed [COORD_BITS_DEF-1:0] a_x;
    logic signed [COORD_BITS_DEF-1:0] a_y;
    logic signed [COORD_BITS_DEF-1:0] a_z;
    logic signed [COORD_BITS_DEF-1:0] b_x;
    logic signed [COORD_BITS_DEF-1:0] b_y;
    logic signed [COORD_BITS_DEF-1:0] b_z;
    logic signed [COORD_BITS_DEF-1:0] c_x;
    logic signed [COORD_BITS_DEF-1:0] c_y;
    logic signed [COORD_BITS_DEF-1:0] c_z;
    logic signed [COORD_BITS_DEF-1:0] q_x;
    logic signed [COORD_BITS_DEF-1:0] q_y;
    logic signed [COORD_BITS_DEF-1:0] q_z;
  } bpt_in_t;

  typedef struct packed {
    logic signed [W_BITS-1:0] weight_first;
    logic signed [W_BITS-1:0] weight_second;
    logic signed [W_BITS-1:0] weight_third;
    logic                     inside_res;
    logic                     degenerate;
  } bpt_out_t;

  // flow control bundle with advance and flush bits
  typedef struct packed {
    logic adv;
    logic flush;
  } bpt_ctl_t;

endpackage

/* sv/bpt_div.sv */
// pipelined restoring divider, one quotient bit per stage
// produces floor(n * 2^FRAC / d) saturated to W_BITS signed, d > 0
module bpt_div #(
  parameter int NB = 72,
  parameter int FRAC = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_vld,
  input  logic signed [NB-1:0]           in_n,
  input  logic        [NB-1:0]           in_d,
  output logic                           out_vld,
  output logic signed [bpt_pkg::W_BITS-1:0] out_q
);
  import bpt_pkg::*;

  localparam int QB = W_BITS - 1;
  localparam int AB = NB + FRAC + 1;
  localparam int DB = NB + QB + 1;

  logic [QB:0]         vld_r;
  logic [AB-1:0]       rem_r  [QB+1];
  logic [NB-1:0]       den_r  [QB+1];
  logic [QB-1:0]       quo_r  [QB+1];
  logic                neg_r  [QB+1];
  logic                sat_r  [QB+1];

  logic [NB-1:0] mag;
  logic [AB-1:0] a0;
  logic [DB-1:0] lim;
  logic [W_BITS-1:0] fin;

  always_comb begin
    mag = in_n[NB-1] ? NB'(-in_n) : NB'(in_n);
    a0  = AB'(mag) << FRAC;
    lim = DB'(in_d) << QB;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[QB-1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= a0;
      den_r[0] <= in_d;
      quo_r[0] <= '0;
      neg_r[0] <= in_n[NB-1];
      sat_r[0] <= (DB'(a0) >= lim);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_st
    localparam int BIT = QB - 1 - s;
    logic [DB-1:0] ds;
    logic          ge;
    assign ds = DB'(den_r[s]) << BIT;
    assign ge = DB'(rem_r[s]) >= ds;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= ge ? AB'(DB'(rem_r[s]) - ds) : rem_r[s];
        quo_r[s+1] <= quo_r[s] | (QB'(ge) << BIT);
        den_r[s+1] <= den_r[s];
        neg_r[s+1] <= neg_r[s];
        sat_r[s+1] <= sat_r[s];
      end
    end
  end

  always_comb begin
    if (sat_r[QB])
      fin = neg_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    else if (neg_r[QB])
      fin = -({1'b0, quo_r[QB]} + W_BITS'(rem_r[QB] != '0));
    else
      fin = {1'b0, quo_r[QB]};
  end

  assign out_vld = vld_r[QB];
  assign out_q   = fin;
endmodule

/* sv/bpt_front.sv */
// differences, dot products, then determinant and numerators over stages
module bpt_front #(
  parameter int COORD_BITS = bpt_pkg::COORD_BITS_DEF,
  parameter int NB = 72
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  bpt_pkg::bpt_in_t        in_data,
  output logic                    out_vld,
  output logic signed [NB-1:0]    out_n1,
  output logic signed [NB-1:0]    out_n2,
  output logic signed [NB-1:0]    out_n3,
  output logic        [NB-1:0]    out_det,
  output logic                    out_degen
);
  import bpt_pkg::*;

  localparam int VB = COORD_BITS + 1;
  localparam int PB = 2 * VB + 2;
  localparam int HB = 2 * PB;

  logic [4:0] vld_r;
  logic signed [VB-1:0] v2_r [3], v3_r [3], vp_r [3];
  logic signed [PB-1:0] d22_r, d33_r, d23_r, d2p_r, d3p_r;
  logic signed [HB-1:0] t1_r, t2_r, m1_r, m2_r, m3_r, m4_r;
  logic signed [NB-1:0] det_r, n2_r, n3_r, n1_r;
  logic                 z22_r, z22b_r, dg_r;
  logic signed [NB-1:0] det_q_r, n2_q_r, n3_q_r;

  logic signed [COORD_BITS-1:0] av [3], bv [3], cv [3], qv [3];

  always_comb begin
    av[0] = COORD_BITS'(in_data.a_x); av[1] = COORD_BITS'(in_data.a_y);
    av[2] = COORD_BITS'(in_data.a_z);
    bv[0] = COORD_BITS'(in_data.b_x); bv[1] = COORD_BITS'(in_data.b_y);
    bv[2] = COORD_BITS'(in_data.b_z);
    cv[0] = COORD_BITS'(in_data.c_x); cv[1] = COORD_BITS'(in_data.c_y);
    cv[2] = COORD_BITS'(in_data.c_z);
    qv[0] = COORD_BITS'(in_data.q_x); qv[1] = COORD_BITS'(in_data.q_y);
    qv[2] = COORD_BITS'(in_data.q_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[3:0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        v2_r[k] <= VB'(bv[k]) - VB'(av[k]);
        v3_r[k] <= VB'(cv[k]) - VB'(av[k]);
        vp_r[k] <= VB'(qv[k]) - VB'(av[k]);
      end
      d22_r <= PB'(v2_r[0]) * PB'(v2_r[0]) + PB'(v2_r[1]) * PB'(v2_r[1])
             + PB'(v2_r[2]) * PB'(v2_r[2]);
      d33_r <= PB'(v3_r[0]) * PB'(v3_r[0]) + PB'(v3_r[1]) * PB'(v3_r[1])
             + PB'(v3_r[2]) * PB'(v3_r[2]);
      d23_r <= PB'(v2_r[0]) * PB'(v3_r[0]) + PB'(v2_r[1]) * PB'(v3_r[1])
             + PB'(v2_r[2]) * PB'(v3_r[2]);
      d2p_r <= PB'(v2_r[0]) * PB'(vp_r[0]) + PB'(v2_r[1]) * PB'(vp_r[1])
             + PB'(v2_r[2]) * PB'(vp_r[2]);
      d3p_r <= PB'(v3_r[0]) * PB'(vp_r[0]) + PB'(v3_r[1]) * PB'(vp_r[1])
             + PB'(v3_r[2]) * PB'(vp_r[2]);
      // products of dot products
      t1_r <= HB'(d22_r) * HB'(d33_r);
      t2_r <= HB'(d23_r) * HB'(d23_r);
      m1_r <= HB'(d33_r) * HB'(d2p_r);
      m2_r <= HB'(d23_r) * HB'(d3p_r);
      m3_r <= HB'(d22_r) * HB'(d3p_r);
      m4_r <= HB'(d23_r) * HB'(d2p_r);
      z22_r <= (d22_r == '0);
      det_r <= NB'(t1_r) - NB'(t2_r);
      n2_r  <= NB'(m1_r) - NB'(m2_r);
      n3_r  <= NB'(m3_r) - NB'(m4_r);
      z22b_r <= z22_r;
      det_q_r <= det_r;
      n2_q_r  <= n2_r;
      n3_q_r  <= n3_r;
      n1_r    <= det_r - n2_r - n3_r;
      dg_r    <= z22b_r || (det_r == '0);
    end
  end

  assign out_vld   = vld_r[4];
  assign out_n1    = n1_r;
  assign out_n2    = n2_q_r;
  assign out_n3    = n3_q_r;
  assign out_det   = NB'(det_q_r);
  assign out_degen = dg_r;
endmodule

/* sv/barycentric_point_in_triangle.sv */
// barycentric point-in-triangle test, streaming
// in_valid/in_ready carries one beat per triangle plus query point (Q8.8);
// out_valid/out_ready returns three Q7.16 weights, inside and degenerate.
// the pipeline has 5 front stages for differences, dot products,
// determinant and numerators, 24 divider stages and one output register.
// throughput: one beat per cycle while the output is not stalled; the
// divider lanes are fully pipelined, one quotient bit per stage, which sets the depth.
// the whole pipeline advances together; when the receiver stalls with a
// result held, every stage freezes and in_ready drops, nothing is lost.
// in_ready is low exactly while a result is held at the output and out_ready is low.
// degenerate triangles give zero weights with inside cleared.
// synchronous reset clears all valid bits; payload is not reset.
module barycentric_point_in_triangle #(
  parameter int WEIGHT_FRAC_BITS = bpt_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpt_pkg::bpt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bpt_pkg::bpt_out_t out_data
);
  import bpt_pkg::*;

  localparam int NB = 4 * (COORD_BITS_DEF + 2) + 4;
  localparam int LAT = W_BITS;

  logic adv;
  logic f_vld, f_dg;
  logic signed [NB-1:0] n1, n2, n3;
  logic [NB-1:0] det, det_safe;
  logic v1, v2, v3;
  logic signed [W_BITS-1:0] q1, q2, q3;
  logic [LAT-1:0] dg_r, ins_r;
  logic out_valid_r;
  bpt_out_t out_r;

  // stall whenever the output holds a beat that is not taken
  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;

  bpt_front #(.COORD_BITS(COORD_BITS_DEF), .NB(NB)) u_front (
    .clk, .rst_n, .adv, .in_vld(in_valid && in_ready), .in_data,
    .out_vld(f_vld), .out_n1(n1), .out_n2(n2), .out_n3(n3),
    .out_det(det), .out_degen(f_dg));

  assign det_safe = f_dg ? NB'(1) : det;

  bpt_div #(.NB(NB), .FRAC(WEIGHT_FRAC_BITS)) u_d1 (
    .clk, .rst_n, .adv, .in_vld(f_vld), .in_n(n1), .in_d(det_safe),
    .out_vld(v1), .out_q(q1));
  bpt_div #(.NB(NB), .FRAC(WEIGHT_FRAC_BITS)) u_d2 (
    .clk, .rst_n, .adv, .in_vld(f_vld), .in_n(n2), .in_d(det_safe),
    .out_vld(v2), .out_q(q2));
  bpt_div #(.NB(NB), .FRAC(WEIGHT_FRAC_BITS)) u_d3 (
    .clk, .rst_n, .adv, .in_vld(f_vld), .in_n(n3), .in_d(det_safe),
    .out_vld(v3), .out_q(q3));

  // side flags ride alongside the divider lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      dg_r  <= {dg_r[LAT-2:0], f_dg};
      ins_r <= {ins_r[LAT-2:0], !f_dg && !n1[NB-1] && !n2[NB-1] && !n3[NB-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.weight_first  <= dg_r[W_BITS-1] ? '0 : q1;
      out_r.weight_second <= dg_r[W_BITS-1] ? '0 : q2;
      out_r.weight_third  <= dg_r[W_BITS-1] ? '0 : q3;
      out_r.inside_res    <= ins_r[W_BITS-1];
      out_r.degenerate    <= dg_r[W_BITS-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (v1 == v2) && (v1 == v3)) else $error("divider lanes out of step");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed during stall");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.inside_res && out_data.degenerate))
    else $error("inside and degenerate both set");
`endif
endmodule
